// File: rtl/string_literal_unescaper_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef STRING_LITERAL_UNESCAPER_UNIT_ASSERT_SVH
`define STRING_LITERAL_UNESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/slu_pkg.sv
// Package: shared types and constants of the string literal unescaper.
`timescale 1ns / 1ps
`default_nettype none

package slu_pkg;

  localparam int SLU_QUEUE_DEPTH = 4;
  localparam int SLU_MAX_RES     = 3;

  // literal kinds
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_BYTES  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EOL     = 2'd1;
  localparam logic [1:0] ERR_ESCAPE  = 2'd2;
  localparam logic [1:0] ERR_HEX     = 2'd3;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       done_res;
    logic       give_back;
    logic [1:0] error_code;
  } res_t;

  // all results caused by one input byte (cnt is 1..3 in the queue)
  typedef struct packed {
    res_t [SLU_MAX_RES-1:0] ent;
    logic [1:0]             cnt;
  } pkt_t;

endpackage

`default_nettype wire

// File: rtl/slu_front.sv
// Front end: accepts source bytes, runs the decode state machine, builds result packets.
`timescale 1ns / 1ps
`default_nettype none

module slu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_begin_req,
  input  wire logic [1:0]   in_kind,
  input  wire logic         q_full,
  output logic              q_push,
  output slu_pkg::pkt_t     q_data
);
  import slu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPEN1 = 3'd1,
    PH_OPEN2 = 3'd2,
    PH_BODY  = 3'd3,
    PH_ESC   = 3'd4,
    PH_HEX1  = 3'd5,
    PH_HEX2  = 3'd6
  } phase_t;

  typedef struct packed {
    logic   emit;
    res_t   res;
    phase_t ph;
    logic   pend_set;
  } body_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  phase_t     phase_r, phase_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic       triple_r, triple_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [3:0] hexhi_r, hexhi_nxt;

  logic       accept;
  logic       run_body;
  logic [1:0] pre_cnt;
  body_t      bd;
  pkt_t       pkt;
  logic [4:0] hv;
  logic [8:0] em;
  logic [7:0] code;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r            = '0;
    r.data       = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_flag(input logic done, input logic gb, input logic [1:0] err);
    res_t r;
    r            = '0;
    r.done_res   = done;
    r.give_back  = gb;
    r.error_code = err;
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39)      v = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c[3:0] + 4'd9)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c[3:0] + 4'd9)};
    return v;
  endfunction

  // {valid, mapped byte}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] m;
    m = '0;
    unique case (c)
      8'h22:   m = {1'b1, 8'h22};
      8'h27:   m = {1'b1, 8'h27};
      8'h5C:   m = {1'b1, 8'h5C};
      8'h6E:   m = {1'b1, 8'h0A};
      8'h72:   m = {1'b1, 8'h0D};
      8'h74:   m = {1'b1, 8'h09};
      8'h61:   m = {1'b1, 8'h07};
      8'h62:   m = {1'b1, 8'h08};
      8'h66:   m = {1'b1, 8'h0C};
      8'h76:   m = {1'b1, 8'h0B};
      8'h30:   m = {1'b1, 8'h00};
      default: m = '0;
    endcase
    return m;
  endfunction

  // plain body byte: closing quote, end of line/source, escape start or data
  function automatic body_t body_fn(input logic [7:0] c, input logic [7:0] q,
                                    input logic trip, input logic [1:0] knd);
    body_t b;
    b    = '0;
    b.ph = PH_BODY;
    if (c == q) begin
      if (trip) begin
        b.pend_set = 1'b1;
      end else begin
        b.ph   = PH_IDLE;
        b.emit = 1'b1;
        b.res  = mk_flag(1'b1, 1'b0, ERR_NONE);
      end
    end else if (c == CH_NUL || (c == CH_LF && !trip)) begin
      b.ph   = PH_IDLE;
      b.emit = 1'b1;
      b.res  = mk_flag(1'b0, 1'b0, ERR_EOL);
    end else if (c == CH_BSLASH && knd != KIND_RAW) begin
      b.ph = PH_ESC;
    end else begin
      b.emit = 1'b1;
      b.res  = mk_byte(c);
    end
    return b;
  endfunction

  assign accept = in_valid && !q_full;
  assign bd     = body_fn(in_byte, quote_r, triple_r, kind_r);
  assign hv     = hex_val(in_byte);
  assign em     = esc_map(in_byte);
  assign code   = {hexhi_r, hv[3:0]};

  always_comb begin
    phase_nxt  = phase_r;
    quote_nxt  = quote_r;
    triple_nxt = triple_r;
    kind_nxt   = kind_r;
    pend_nxt   = pend_r;
    hexhi_nxt  = hexhi_r;
    pkt        = '0;
    pre_cnt    = 2'd0;
    run_body   = 1'b0;

    if (in_begin_req) begin
      quote_nxt  = in_byte;
      kind_nxt   = in_kind;
      triple_nxt = 1'b0;
      pend_nxt   = 2'd0;
      hexhi_nxt  = 4'd0;
      phase_nxt  = PH_OPEN1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_OPEN1: begin
          if (in_byte == quote_r) phase_nxt = PH_OPEN2;
          else                    run_body  = 1'b1;
        end
        PH_OPEN2: begin
          if (in_byte == quote_r) begin
            triple_nxt = 1'b1;
            phase_nxt  = PH_BODY;
          end else begin
            // empty literal; this byte belongs to what follows
            phase_nxt  = PH_IDLE;
            pkt.ent[0] = mk_flag(1'b1, 1'b1, ERR_NONE);
            pkt.cnt    = 2'd1;
          end
        end
        PH_BODY: begin
          if (pend_r == 2'd1) begin
            if (in_byte == quote_r) begin
              pend_nxt = 2'd2;
            end else begin
              pend_nxt   = 2'd0;
              pkt.ent[0] = mk_byte(quote_r);
              pre_cnt    = 2'd1;
              run_body   = 1'b1;
            end
          end else if (pend_r >= 2'd2) begin
            pend_nxt = 2'd0;
            if (in_byte == quote_r) begin
              phase_nxt  = PH_IDLE;
              pkt.ent[0] = mk_flag(1'b1, 1'b0, ERR_NONE);
              pkt.cnt    = 2'd1;
            end else begin
              pkt.ent[0] = mk_byte(quote_r);
              pkt.ent[1] = mk_byte(quote_r);
              pre_cnt    = 2'd2;
              run_body   = 1'b1;
            end
          end else begin
            run_body = 1'b1;
          end
        end
        PH_ESC: begin
          if (in_byte == CH_X) begin
            phase_nxt = PH_HEX1;
          end else if (!em[8]) begin
            phase_nxt  = PH_IDLE;
            pkt.ent[0] = mk_flag(1'b0, 1'b0, ERR_ESCAPE);
            pkt.cnt    = 2'd1;
          end else begin
            phase_nxt  = PH_BODY;
            pkt.ent[0] = mk_byte(em[7:0]);
            pkt.cnt    = 2'd1;
          end
        end
        PH_HEX1: begin
          if (!hv[4]) begin
            phase_nxt  = PH_IDLE;
            pkt.ent[0] = mk_flag(1'b0, 1'b0, ERR_HEX);
            pkt.cnt    = 2'd1;
          end else begin
            hexhi_nxt = hv[3:0];
            phase_nxt = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hv[4]) begin
            phase_nxt  = PH_IDLE;
            pkt.ent[0] = mk_flag(1'b0, 1'b0, ERR_HEX);
            pkt.cnt    = 2'd1;
          end else begin
            phase_nxt = PH_BODY;
            if (kind_r == KIND_BYTES || !code[7]) begin
              pkt.ent[0] = mk_byte(code);
              pkt.cnt    = 2'd1;
            end else begin
              // UTF-8 two-byte form
              pkt.ent[0] = mk_byte(8'hC0 | {6'd0, code[7:6]});
              pkt.ent[1] = mk_byte(8'h80 | {2'd0, code[5:0]});
              pkt.cnt    = 2'd2;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      if (run_body) begin
        phase_nxt = bd.ph;
        if (bd.pend_set) pend_nxt = 2'd1;
        if (bd.emit) pkt.ent[pre_cnt] = bd.res;
        pkt.cnt = 2'(pre_cnt + {1'b0, bd.emit});
      end
    end
  end

  assign q_push = accept && (pkt.cnt != 2'd0);
  assign q_data = pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      quote_r  <= '0;
      triple_r <= 1'b0;
      kind_r   <= '0;
      pend_r   <= '0;
      hexhi_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      quote_r  <= quote_nxt;
      triple_r <= triple_nxt;
      kind_r   <= kind_nxt;
      pend_r   <= pend_nxt;
      hexhi_r  <= hexhi_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/slu_queue.sv
// Packet queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module slu_queue #(
  parameter int DEPTH = slu_pkg::SLU_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire slu_pkg::pkt_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output slu_pkg::pkt_t       head,
  output logic                empty
);
  import slu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= CNT_W'(count_r + 1'b1);
      else if (pop && !push) count_r <= CNT_W'(count_r - 1'b1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/slu_back.sv
// Back end: walks each packet and drives one result per cycle, while out_stall is low, through an output register.
`timescale 1ns / 1ps
`default_nettype none

module slu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire slu_pkg::pkt_t  head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_done_res,
  output logic                out_give_back,
  output logic [1:0]          out_error_code,
  output logic                out_last
);
  import slu_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  res_t       res_r;
  logic       last_r;
  logic       load;
  logic       at_last;
  res_t       sel;

  assign load    = !empty && (!valid_r || !out_stall);
  assign sel     = head.ent[idx_r];
  assign at_last = (idx_r == 2'(head.cnt - 2'd1));
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= at_last ? 2'd0 : 2'(idx_r + 2'd1);
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= sel;
      last_r <= at_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = res_r.data;
  assign out_byte_valid = res_r.byte_valid;
  assign out_done_res   = res_r.done_res;
  assign out_give_back  = res_r.give_back;
  assign out_error_code = res_r.error_code;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// File: rtl/string_literal_unescaper_unit.sv
// Top level: string literal escape decoder (front end, packet queue, back end).
//
//  channel | ports                                   | direction | transfer when
//  --------+-----------------------------------------+-----------+-------------------------
//  input   | in_byte, in_begin_req, in_kind          | in        | in_valid && !in_stall
//  result  | out_byte, out_byte_valid, out_done_res, | out       | out_valid && !out_stall
//          | out_give_back, out_error_code, out_last |           |
//
// One source byte is taken per cycle while the packet queue has room.
// A byte yields 0 to 3 results; the back end's output register sends one result per
// cycle while out_stall is low.
// With an empty queue a result passes through the queue and then the back end's output
// register before out_valid rises.
// Reset (rst_n low at a clock edge) returns the decoder to idle and empties the queue.
// in_stall rises only when the queue holds QUEUE_DEPTH packets; out_stall holds the
// output register and the queue then fills behind it.
`timescale 1ns / 1ps
`default_nettype none

module string_literal_unescaper_unit #(
  parameter int QUEUE_DEPTH = slu_pkg::SLU_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_begin_req,
  input  wire logic [1:0] in_kind,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_done_res,
  output logic            out_give_back,
  output logic [1:0]      out_error_code,
  output logic            out_last
);
  import slu_pkg::*;

  // front end -> queue
  logic q_push;
  logic q_full;
  pkt_t q_wdata;
  // queue -> back end
  logic q_pop;
  logic q_empty;
  pkt_t q_head;

  assign in_stall = q_full;

  // Decode state machine; one packet per byte that produces results.
  slu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_begin_req (in_begin_req),
    .in_kind      (in_kind),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // Decouples the byte-rate front from the result-rate back end.
  slu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Serializes each packet; marks the last result of each byte.
  slu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_give_back  (out_give_back),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/slu_checker.sv
// Port-level checker for the string literal unescaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "string_literal_unescaper_unit_assert.svh"

module slu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_done_res,
  input wire logic       out_give_back,
  input wire logic [1:0] out_error_code,
  input wire logic       out_last
);
  import slu_pkg::*;

  `SLU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SLU_ASSERT_NOW(a_flag_zero_byte, out_valid && !out_byte_valid, out_byte == 8'h00, "nonzero byte on flag result")
  `SLU_ASSERT_NOW(a_byte_no_flags, out_valid && out_byte_valid, !out_done_res && !out_give_back && out_error_code == ERR_NONE, "data result carries flags")
  `SLU_ASSERT_NOW(a_give_back_done, out_valid && out_give_back, out_done_res && out_last, "give_back without completion")
  `SLU_ASSERT_NOW(a_end_is_last, out_valid && (out_done_res || out_error_code != ERR_NONE), out_last, "completion or error not last")

endmodule

bind string_literal_unescaper_unit slu_checker u_slu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_done_res   (out_done_res),
  .out_give_back  (out_give_back),
  .out_error_code (out_error_code),
  .out_last       (out_last)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the string literal unescaper: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
  import slu_pkg::*;

  // Source characters that drive the decoder's control flow.
  localparam logic [7:0] CH_EOS     = 8'h00;  // end of source
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DQ      = 8'h22;
  localparam logic [7:0] CH_SQ      = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_HEX_ESC = 8'h78;  // 'x'

  // Every escape letter the decoder knows (besides x).
  localparam string ESC_SET = "\"'\\nrtabfv0";

  // Decoder states of the prediction.
  typedef enum logic [2:0] {
    ST_IDLE, ST_OPEN1, ST_OPEN2, ST_BODY, ST_ESC, ST_HEX1, ST_HEX2
  } dec_state_t;

  // One result transfer as seen on the out_ ports.
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       done;
    logic       give_back;
    logic [1:0] err;
    logic       last;
  } out_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_begin_req = 1'b0;
  logic [1:0] in_kind = KIND_NORMAL;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_done_res;
  logic       out_give_back;
  logic [1:0] out_error_code;
  logic       out_last;

  // Idle rates, percent of cycles, for the sender and the receiver.
  int send_pct = 0;
  int recv_pct = 0;
  int fail_count = 0;
  int items_sent = 0;

  // Predicted decoder state.
  dec_state_t m_state = ST_IDLE;
  logic [7:0] m_quote = 8'h00;
  logic       m_triple = 1'b0;
  logic [1:0] m_kind = KIND_NORMAL;
  logic [1:0] m_held = 2'd0;   // quotes held in a triple body
  logic [3:0] m_hex_hi = 4'h0;

  out_item_t step_out[$];      // results of the byte being decoded
  out_item_t decoded_q[$];     // decoded results still to come out, oldest first

  string_literal_unescaper_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_begin_req   (in_begin_req),
    .in_kind        (in_kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_give_back  (out_give_back),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // {known, value} of the character after a backslash
  function automatic logic [8:0] escape_value(input logic [7:0] c);
    case (c)
      CH_DQ:     return {1'b1, CH_DQ};
      CH_SQ:     return {1'b1, CH_SQ};
      CH_BSLASH: return {1'b1, CH_BSLASH};
      "n":       return {1'b1, 8'h0A};
      "r":       return {1'b1, 8'h0D};
      "t":       return {1'b1, 8'h09};
      "a":       return {1'b1, 8'h07};
      "b":       return {1'b1, 8'h08};
      "f":       return {1'b1, 8'h0C};
      "v":       return {1'b1, 8'h0B};
      "0":       return {1'b1, 8'h00};
      default:   return 9'h000;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] d, input logic v, input logic dn,
                               input logic gb, input logic [1:0] e);
    out_item_t r;
    r.data = d;
    r.byte_valid = v;
    r.done = dn;
    r.give_back = gb;
    r.err = e;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // Plain body character: closing quote, line/source end, escape start or data.
  function automatic void body_char(input logic [7:0] c);
    if (c == m_quote) begin
      if (m_triple) begin
        m_held = 2'd1;
      end else begin
        m_state = ST_IDLE;
        emit(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
      end
    end else if (c == CH_EOS || (c == CH_NL && !m_triple)) begin
      m_state = ST_IDLE;
      emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_EOL);
    end else if (c == CH_BSLASH && m_kind != KIND_RAW) begin
      m_state = ST_ESC;
    end else begin
      emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end
  endfunction

  // Advances the predicted decoder by one accepted byte and queues its results.
  function automatic void decode_source_byte(input logic [7:0] b, input logic beg,
                                             input logic [1:0] k);
    logic [8:0] ev;
    logic [7:0] code;
    int         dg;
    bit         skip;
    out_item_t  r;
    step_out.delete();
    skip = 1'b0;
    if (beg) begin
      // a new opening quote drops whatever literal was in progress
      m_quote = b;
      m_kind = k;
      m_triple = 1'b0;
      m_held = 2'd0;
      m_hex_hi = 4'h0;
      m_state = ST_OPEN1;
    end else begin
      case (m_state)
        ST_OPEN1: begin
          if (b == m_quote) begin
            m_state = ST_OPEN2;
          end else begin
            m_state = ST_BODY;
            body_char(b);
          end
        end
        ST_OPEN2: begin
          if (b == m_quote) begin
            m_triple = 1'b1;
            m_state = ST_BODY;
          end else begin
            // empty literal; this byte belongs to what follows
            m_state = ST_IDLE;
            emit(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
          end
        end
        ST_BODY: begin
          if (m_held == 2'd1) begin
            if (b == m_quote) begin
              m_held = 2'd2;
              skip = 1'b1;
            end else begin
              m_held = 2'd0;
              emit(m_quote, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
          end else if (m_held >= 2'd2) begin
            m_held = 2'd0;
            if (b == m_quote) begin
              m_state = ST_IDLE;
              emit(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
              skip = 1'b1;
            end else begin
              emit(m_quote, 1'b1, 1'b0, 1'b0, ERR_NONE);
              emit(m_quote, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
          end
          if (!skip) body_char(b);
        end
        ST_ESC: begin
          if (b == CH_HEX_ESC) begin
            m_state = ST_HEX1;
          end else begin
            ev = escape_value(b);
            if (!ev[8]) begin
              m_state = ST_IDLE;
              emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_ESCAPE);
            end else begin
              m_state = ST_BODY;
              emit(ev[7:0], 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
          end
        end
        ST_HEX1: begin
          dg = hex_digit(b);
          if (dg < 0) begin
            m_state = ST_IDLE;
            emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_HEX);
          end else begin
            m_hex_hi = dg[3:0];
            m_state = ST_HEX2;
          end
        end
        ST_HEX2: begin
          dg = hex_digit(b);
          if (dg < 0) begin
            m_state = ST_IDLE;
            emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_HEX);
          end else begin
            code = {m_hex_hi, dg[3:0]};
            m_state = ST_BODY;
            // bytes literals keep the raw value, text goes out as UTF-8
            if (m_kind == KIND_BYTES || code <= 8'h7F) begin
              emit(code, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end else begin
              emit(8'hC0 | (code >> 6), 1'b1, 1'b0, 1'b0, ERR_NONE);
              emit(8'h80 | (code & 8'h3F), 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
          end
        end
        default: ;  // idle: stray bytes are dropped
      endcase
    end
    for (int i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      decoded_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    out_item_t w;
    if (decoded_q.size() == 0) begin
      $error("result transfer with nothing expected: out_byte=%0h err=%0d",
             out_byte, out_error_code);
      fail_count++;
    end else begin
      w = decoded_q.pop_front();
      compare_field("out_byte", w.data, out_byte);
      compare_field("out_byte_valid", 8'(w.byte_valid), 8'(out_byte_valid));
      compare_field("out_done_res", 8'(w.done), 8'(out_done_res));
      compare_field("out_give_back", 8'(w.give_back), 8'(out_give_back));
      compare_field("out_error_code", 8'(w.err), 8'(out_error_code));
      compare_field("out_last", 8'(w.last), 8'(out_last));
    end
  endtask

  // Both channels sampled at the rising edge. The result check comes first: a result
  // can never stem from the byte transferred at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) decode_source_byte(in_byte, in_begin_req, in_kind);
    end
  end

  // Receiver back-pressure, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One input transfer. Entered and left at a falling edge; valid stays high on
  // return so back-to-back bytes need no second assignment in one step.
  task automatic send_byte(input logic [7:0] b, input logic beg, input logic [1:0] k);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_begin_req <= beg;
    // kind only matters with an opening quote; elsewhere it is noise
    in_kind <= beg ? k : 2'($urandom_range(0, 3));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Sender holds off until every predicted result has been transferred.
  // Always waits for a falling edge so valid is driven once per step.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (decoded_q.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
  endfunction

  // Body character that neither ends the literal nor starts an escape.
  function automatic logic [7:0] pick_plain(input logic [7:0] q, input bit triple);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(32, 126));
    end while (c == q || c == CH_BSLASH || (c == CH_NL && !triple));
    return c;
  endfunction

  task automatic test_idle_byte_ignored();
    send_byte(8'hFF, 1'b0, KIND_NORMAL);
  endtask

  task automatic test_hex_escapes();
    // kind 3 decodes as text: \xFf is two UTF-8 bytes, then a bad second digit
    send_byte(CH_DQ, 1'b1, 2'd3);
    send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
    send_byte(CH_HEX_ESC, 1'b0, KIND_NORMAL);
    send_byte("F", 1'b0, KIND_NORMAL);
    send_byte("f", 1'b0, KIND_NORMAL);
    send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
    send_byte(CH_HEX_ESC, 1'b0, KIND_NORMAL);
    send_byte("7", 1'b0, KIND_NORMAL);
    send_byte("g", 1'b0, KIND_NORMAL);
    // bytes literal keeps 0x80 as one byte; left open, the next test drops it
    send_byte(CH_SQ, 1'b1, KIND_BYTES);
    send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
    send_byte(CH_HEX_ESC, 1'b0, KIND_NORMAL);
    send_byte("8", 1'b0, KIND_NORMAL);
    send_byte("0", 1'b0, KIND_NORMAL);
  endtask

  task automatic test_quote_forms();
    // zero as the quote character: empty literal, trailing byte given back
    send_byte(CH_EOS, 1'b1, KIND_NORMAL);
    send_byte(CH_EOS, 1'b0, KIND_NORMAL);
    send_byte(8'h01, 1'b0, KIND_NORMAL);
    // raw triple literal: two held quotes released by a newline, then the close
    send_byte(CH_DQ, 1'b1, KIND_RAW);
    repeat (2) send_byte(CH_DQ, 1'b0, KIND_NORMAL);
    repeat (2) send_byte(CH_DQ, 1'b0, KIND_NORMAL);
    send_byte(CH_NL, 1'b0, KIND_NORMAL);
    repeat (3) send_byte(CH_DQ, 1'b0, KIND_NORMAL);
  endtask

  task automatic test_error_paths();
    // newline inside a single-quoted literal
    send_byte(CH_SQ, 1'b1, KIND_NORMAL);
    send_byte(CH_NL, 1'b0, KIND_NORMAL);
    // a second opening quote replaces the first, then the source ends
    send_byte(CH_DQ, 1'b1, KIND_NORMAL);
    send_byte(CH_SQ, 1'b1, KIND_BYTES);
    send_byte(CH_EOS, 1'b0, KIND_NORMAL);
  endtask

  // One literal with random content: mostly well formed, some ending in an error
  // or left unfinished.
  task automatic send_literal();
    logic [7:0] q;
    logic [7:0] c;
    logic [8:0] ev;
    logic [1:0] k;
    bit         triple;
    int         pick;
    int         body_len;
    pick = $urandom_range(0, 9);
    if (pick < 5) q = CH_DQ;
    else if (pick < 9) q = CH_SQ;
    else q = 8'($urandom_range(0, 255));
    k = 2'($urandom_range(0, 3));
    triple = 1'($urandom_range(0, 1));
    send_byte(q, 1'b1, k);
    if (triple) repeat (2) send_byte(q, 1'b0, KIND_NORMAL);
    body_len = $urandom_range(0, 6);
    for (int i = 0; i < body_len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_byte(pick_plain(q, triple), 1'b0, KIND_NORMAL);
        4, 5: begin
          send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
          send_byte(ESC_SET[$urandom_range(0, 10)], 1'b0, KIND_NORMAL);
        end
        6, 7: begin
          send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
          send_byte(CH_HEX_ESC, 1'b0, KIND_NORMAL);
          send_byte(hex_char($urandom_range(0, 15)), 1'b0, KIND_NORMAL);
          send_byte(hex_char($urandom_range(0, 15)), 1'b0, KIND_NORMAL);
        end
        8: begin
          // lone quotes inside a triple body
          if (triple) repeat ($urandom_range(1, 2)) send_byte(q, 1'b0, KIND_NORMAL);
          send_byte(pick_plain(q, triple), 1'b0, KIND_NORMAL);
        end
        default: send_byte(triple ? CH_NL : pick_plain(q, 1'b0), 1'b0, KIND_NORMAL);
      endcase
    end
    case ($urandom_range(0, 9))
      6: send_byte((!triple && $urandom_range(0, 1)) ? CH_NL : CH_EOS, 1'b0, KIND_NORMAL);
      7: begin
        send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
        do begin
          c = 8'($urandom_range(0, 255));
          ev = escape_value(c);
        end while (c == CH_HEX_ESC || ev[8]);
        send_byte(c, 1'b0, KIND_NORMAL);
      end
      8: begin
        send_byte(CH_BSLASH, 1'b0, KIND_NORMAL);
        send_byte(CH_HEX_ESC, 1'b0, KIND_NORMAL);
        if ($urandom_range(0, 1)) send_byte(hex_char($urandom_range(0, 15)), 1'b0, KIND_NORMAL);
        do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
        send_byte(c, 1'b0, KIND_NORMAL);
      end
      9: ;  // left open; the next opening quote drops it
      default: begin
        repeat (triple ? 3 : 1) send_byte(q, 1'b0, KIND_NORMAL);
        // an empty single-quoted literal only completes on the byte after it
        if ((!triple && body_len == 0) || $urandom_range(0, 3) == 0)
          send_byte(pick_plain(q, 1'b0), 1'b0, KIND_NORMAL);
      end
    endcase
  endtask

  task automatic test_random_literals(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray byte between literals, now and then a bare opening quote
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  2'($urandom_range(0, 3)));
      end else begin
        send_literal();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pct = 35;
    recv_pct = 51;
    test_idle_byte_ignored();
    test_hex_escapes();
    test_quote_forms();
    test_error_paths();
    test_random_literals(100);
    wait_drain();  // sender hold-off until the result side is empty

    send_pct = 51;
    recv_pct = 35;
    test_random_literals(100);
    wait_drain();

    send_pct = 0;
    recv_pct = 0;
    test_random_literals(100);
    wait_drain();

    // leave room for any stray late transfer
    repeat (20) @(posedge clk);
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: string_literal_unescaper_unit.f
+incdir+rtl
rtl/slu_pkg.sv
rtl/slu_front.sv
rtl/slu_queue.sv
rtl/slu_back.sv
rtl/string_literal_unescaper_unit.sv
rtl/slu_checker.sv
dv/tb_top.sv
